### hdl/rcda_pkg.sv
// ============================================================================
// rcda_pkg: shared types and constants for the read coverage depth accumulator
// Holds the request op codes, the controller-to-datapath command and status
// bundles, and the default sizes handed down from the top level.
// ============================================================================
`default_nettype none

package rcda_pkg;

    // Default store size and count width.
    localparam int PATH_MAX_DEF    = 4096;
    localparam int COUNT_WIDTH_DEF = 16;

    // Field widths fixed by the request format.
    localparam int OP_W    = 2;
    localparam int FIELD_W = 16;
    localparam int DEPTH_W = 16;
    localparam int CFG_W   = 13;

    // Position arithmetic: a 16-bit offset plus one carry bit.
    localparam int POS_W = FIELD_W + 1;

    // Largest depth the result port can show.
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

    // Request op codes; the fourth code means nothing and is ignored.
    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request fields
        logic setup;     // compute span end, point index at span start
        logic idx_zero;  // point index at the first store entry
        logic step;      // read one covered entry, advance index
        logic clr_wr;    // write zero at the index, advance index
        logic qread;     // read the queried entry
        logic qcap;      // capture the query result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;      // the add request covers no position
        logic run_done;  // the index has reached the span end
        logic clr_last;  // the index sits on the last store entry
    } t_stat;

endpackage

`default_nettype wire

### hdl/rcda_ram.sv
// ============================================================================
// rcda_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module rcda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/rcda_ctrl.sv
// ============================================================================
// rcda_ctrl: sequencer for the read coverage depth accumulator
// Runs the clearing pass, the per-position increment loop of an add request
// and the read-out of a query, and drives the datapath by commands.
// ============================================================================
`default_nettype none

module rcda_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rcda_pkg::OP_W-1:0]     i_op,
    input  wire rcda_pkg::t_stat               i_stat,
    output      rcda_pkg::t_cmd                o_cmd,
    output      logic                          o_busy,
    output      logic                          o_result_valid
);

    import rcda_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_QREAD,
        S_QCAP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_result_valid;
    logic   n_result_valid;
    logic   w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        n_result_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    case (i_op)
                        OP_ADD: begin
                            n_state = S_SETUP;
                        end
                        OP_QUERY: begin
                            n_state = S_QREAD;
                        end
                        OP_CLEAR: begin
                            o_cmd.idx_zero = 1'b1;
                            n_state        = S_CLEAR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_stat.skip ? S_IDLE : S_RUN;
            end
            S_RUN: begin
                // The write of the last increment lands in the cycle that
                // sees the index reach the span end.
                if (i_stat.run_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_QREAD: begin
                o_cmd.qread = 1'b1;
                n_state     = S_QCAP;
            end
            S_QCAP: begin
                o_cmd.qcap     = 1'b1;
                n_result_valid = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered result strobe; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_result_valid <= n_result_valid;
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_result_valid;

endmodule

`default_nettype wire

### hdl/rcda_dp.sv
// ============================================================================
// rcda_dp: datapath of the read coverage depth accumulator
// Holds the request fields, the position index and span end, the depth
// store and the saturating read-modify-write pipeline.
// ============================================================================
`default_nettype none

module rcda_dp #(
    parameter int PATH_MAX    = rcda_pkg::PATH_MAX_DEF,
    parameter int COUNT_WIDTH = rcda_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rcda_pkg::t_cmd                i_cmd,
    output      rcda_pkg::t_stat               o_stat,
    input  wire logic [rcda_pkg::CFG_W-1:0]    i_path_length,
    input  wire logic [rcda_pkg::FIELD_W-1:0]  i_path_offset,
    input  wire logic [rcda_pkg::FIELD_W-1:0]  i_read_offset,
    input  wire logic [rcda_pkg::FIELD_W-1:0]  i_read_length,
    output      logic [rcda_pkg::DEPTH_W-1:0]  o_depth,
    output      logic                          o_out_of_range
);

    import rcda_pkg::*;

    localparam int AW = $clog2(PATH_MAX);
    localparam int IW = $clog2(PATH_MAX + 1);
    localparam logic [POS_W-1:0]       PATH_MAX_POS = POS_W'(PATH_MAX);
    localparam logic [IW-1:0]          LAST_IDX     = IW'(PATH_MAX - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CAP_CNT      = COUNT_WIDTH'(DEPTH_MAX);

    // Request fields.
    logic [FIELD_W-1:0] r_ppos;
    logic [FIELD_W-1:0] r_rpos;
    logic [FIELD_W-1:0] r_rlen;

    // Position index, span end and the pending increment write.
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_end;
    logic          r_wr_valid;
    logic [AW-1:0] r_wr_addr;

    // Query result.
    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] n_depth;
    logic               r_oor;

    logic [POS_W-1:0]       w_plen;
    logic [POS_W-1:0]       w_ppos;
    logic [POS_W-1:0]       w_span_end;
    logic [IW-1:0]          n_end;
    logic                   w_oor;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [COUNT_WIDTH-1:0] w_wdata;
    logic                   w_re;
    logic [AW-1:0]          w_raddr;
    logic [COUNT_WIDTH-1:0] w_rdata;

    // Path length in use, limited to the store size.
    always_comb begin
        w_plen = POS_W'(i_path_length);
        if (w_plen > PATH_MAX_POS) begin
            w_plen = PATH_MAX_POS;
        end
    end

    assign w_ppos = POS_W'(r_ppos);
    assign w_oor  = (w_ppos >= w_plen);

    // Span end: the read's remaining bases, cut at the path end.
    assign w_span_end = w_ppos + POS_W'(r_rlen) - POS_W'(r_rpos);
    assign n_end      = (w_span_end > w_plen) ? IW'(w_plen) : IW'(w_span_end);

    assign o_stat.skip     = w_oor || (r_rpos >= r_rlen);
    assign o_stat.run_done = (r_idx == r_end);
    assign o_stat.clr_last = (r_idx == LAST_IDX);

    // Field capture and span setup.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ppos <= i_path_offset;
            r_rpos <= i_read_offset;
            r_rlen <= i_read_length;
        end
        if (i_cmd.setup) begin
            r_end <= n_end;
        end
    end

    // Index walk and the increment write in the cycle after each read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_wr_valid <= 1'b0;
        end else begin
            if (i_cmd.setup) begin
                r_idx <= IW'(w_ppos);
            end else if (i_cmd.idx_zero) begin
                r_idx <= '0;
            end else if (i_cmd.step || i_cmd.clr_wr) begin
                r_idx <= r_idx + IW'(1);
            end
            r_wr_valid <= i_cmd.step;
        end
        r_wr_addr <= r_idx[AW-1:0];
    end

    // Store ports: zero writes while clearing, saturating increments otherwise.
    assign w_we    = i_cmd.clr_wr || r_wr_valid;
    assign w_waddr = i_cmd.clr_wr ? r_idx[AW-1:0] : r_wr_addr;
    assign w_wdata = i_cmd.clr_wr ? '0 :
                     (w_rdata == COUNT_MAX) ? w_rdata : w_rdata + COUNT_WIDTH'(1);
    assign w_re    = i_cmd.step || (i_cmd.qread && !w_oor);
    assign w_raddr = i_cmd.step ? r_idx[AW-1:0] : r_ppos[AW-1:0];

    rcda_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (PATH_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Query result: count capped to the port width, zero when out of range.
    always_comb begin
        if (w_oor) begin
            n_depth = '0;
        end else if (w_rdata > CAP_CNT) begin
            n_depth = DEPTH_MAX;
        end else begin
            n_depth = DEPTH_W'(w_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.qcap) begin
            r_depth <= n_depth;
            r_oor   <= w_oor;
        end
    end

    assign o_depth        = r_depth;
    assign o_out_of_range = r_oor;

endmodule

`default_nettype wire

### hdl/read_coverage_depth_accumulator_unit.sv
// ============================================================================
// read_coverage_depth_accumulator_unit: per-position read coverage counter
// Top level: configuration port, sequencer and datapath with depth store.
// ============================================================================
// Usage:
//   A request is taken when start is high and busy is low. i_op selects an
//   add (one read placement), a query of one position, or a clear of all
//   depths; the unused code is taken and ignored.
//   An add increments each covered position once, one store entry per cycle
//   through a read-modify-write on the store's two ports: it keeps busy high
//   through the setup state and the increment loop after acceptance, and
//   returns to idle from the setup state when nothing is covered.
//   A query returns its result on o_depth and o_out_of_range with
//   o_result_valid high for one cycle, after the read and capture states; the
//   next request may be taken in that same cycle. The receiver cannot stall.
//   A clear writes zero to every entry, one per cycle, and keeps busy high
//   until the last entry is written. Add and clear requests give no result.
//   After reset the same clearing pass runs with busy high; path_length
//   resets to zero. The APB port takes writes at any time and returns
//   path_length on a read; pready is always high.
// ============================================================================
`default_nettype none

module read_coverage_depth_accumulator_unit #(
    parameter int PATH_MAX    = rcda_pkg::PATH_MAX_DEF,
    parameter int COUNT_WIDTH = rcda_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request channel.
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic [rcda_pkg::OP_W-1:0]     i_op,
    input  wire logic [rcda_pkg::FIELD_W-1:0]  i_path_offset,
    input  wire logic [rcda_pkg::FIELD_W-1:0]  i_read_offset,
    input  wire logic [rcda_pkg::FIELD_W-1:0]  i_read_length,
    // Result channel.
    output      logic                          o_result_valid,
    output      logic [rcda_pkg::DEPTH_W-1:0]  o_depth,
    output      logic                          o_out_of_range,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output      logic [31:0]                   prdata,
    output      logic                          pready
);

    import rcda_pkg::*;

    t_cmd                w_cmd;
    t_stat               w_stat;
    logic [CFG_W-1:0]    r_path_length;
    logic                w_reg_sel;

    // Register decode: path_length is the only register, at addresses zero to three.
    assign w_reg_sel = (paddr[2] == 1'b0);
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? 32'(r_path_length) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_length <= '0;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_path_length <= pwdata[CFG_W-1:0];
        end
    end

    rcda_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_op           (i_op),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    rcda_dp #(
        .PATH_MAX    (PATH_MAX),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_path_length  (r_path_length),
        .i_path_offset  (i_path_offset),
        .i_read_offset  (i_read_offset),
        .i_read_length  (i_read_length),
        .o_depth        (o_depth),
        .o_out_of_range (o_out_of_range)
    );

endmodule

`default_nettype wire

### bench/tb_read_coverage_depth_accumulator_unit.sv
// ============================================================================
// tb_read_coverage_depth_accumulator_unit: self-checking bench for the unit
// Sends add, query, clear and unused requests through the command port and
// reprograms path_length over the APB port between phases. A behavioral
// coverage store predicts every query reply, and a monitor compares each
// reply field by field in arrival order.
// ============================================================================
`default_nettype none

module tb_read_coverage_depth_accumulator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rcda_pkg::*;

    localparam int PATH_MAX     = PATH_MAX_DEF;
    localparam int COUNT_W      = COUNT_WIDTH_DEF;
    localparam int SETTLE_COUNT = 8;
    localparam int HANG_LIMIT   = 4 * PATH_MAX + 2000;

    localparam logic [OP_W-1:0]    OP_UNUSED        = 2'd3;
    localparam logic [2:0]         ADDR_PATH_LENGTH = 3'd0;
    localparam logic [COUNT_W-1:0] COUNT_FULL       = {COUNT_W{1'b1}};

    typedef struct {
        logic [DEPTH_W-1:0] depth;
        logic               off_path;
    } t_depth_reply;

    // Clock, reset and every input of the unit start at known values.
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic [OP_W-1:0]    i_op           = OP_UNUSED;
    logic [FIELD_W-1:0] i_path_offset  = '0;
    logic [FIELD_W-1:0] i_read_offset  = '0;
    logic [FIELD_W-1:0] i_read_length  = '0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [2:0]         paddr          = '0;
    logic [31:0]        pwdata         = '0;
    logic               busy;
    logic               o_result_valid;
    logic [DEPTH_W-1:0] o_depth;
    logic               o_out_of_range;
    logic [31:0]        prdata;
    logic               pready;

    // Behavioral copy of the depth store and the length register.
    logic [COUNT_W-1:0] coverage_counts [PATH_MAX];
    logic [CFG_W-1:0]   cfg_path_length = '0;
    t_depth_reply       replies_due [$];
    int                 error_count     = 0;
    int                 quiet_cycles    = 0;
    bit                 steady_flow     = 1'b0;

    read_coverage_depth_accumulator_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_path_offset  (i_path_offset),
        .i_read_offset  (i_read_offset),
        .i_read_length  (i_read_length),
        .o_result_valid (o_result_valid),
        .o_depth        (o_depth),
        .o_out_of_range (o_out_of_range),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // The store clamps the programmed length to its own size.
    function automatic int visible_length();
        return (int'(cfg_path_length) > PATH_MAX) ? PATH_MAX : int'(cfg_path_length);
    endfunction

    // Apply one accepted request to the behavioral store.
    function automatic void track_coverage(input logic [OP_W-1:0] op,
                                           input logic [FIELD_W-1:0] ppos,
                                           input logic [FIELD_W-1:0] rpos,
                                           input logic [FIELD_W-1:0] rlen);
        int           plen;
        int           span;
        t_depth_reply reply;
        plen = visible_length();
        case (op)
            OP_ADD: begin
                if (int'(ppos) < plen && rpos < rlen) begin
                    span = int'(rlen) - int'(rpos);
                    if (span > plen - int'(ppos)) span = plen - int'(ppos);
                    for (int k = 0; k < span; k++) begin
                        if (coverage_counts[int'(ppos) + k] != COUNT_FULL)
                            coverage_counts[int'(ppos) + k]++;
                    end
                end
            end
            OP_QUERY: begin
                if (int'(ppos) >= plen) begin
                    reply.depth    = '0;
                    reply.off_path = 1'b1;
                end else begin
                    if (longint'(coverage_counts[ppos]) > longint'(DEPTH_MAX))
                        reply.depth = DEPTH_MAX;
                    else
                        reply.depth = DEPTH_W'(coverage_counts[ppos]);
                    reply.off_path = 1'b0;
                end
                replies_due.insert(replies_due.size(), reply);
            end
            OP_CLEAR: begin
                foreach (coverage_counts[i]) coverage_counts[i] = '0;
            end
            default: ;
        endcase
    endfunction

    // Send one request. start stays high after acceptance so that a request
    // with no gap follows back to back; wait_idle lowers it.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [FIELD_W-1:0] ppos,
                                input logic [FIELD_W-1:0] rpos,
                                input logic [FIELD_W-1:0] rlen);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_path_offset <= ppos;
        i_read_offset <= rpos;
        i_read_length <= rlen;
        do @(posedge i_clk); while (busy !== 1'b0);
        track_coverage(op, ppos, rpos, rlen);
    endtask

    // Drop start and wait until the unit is idle and every reply has come.
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (busy !== 1'b0 || replies_due.size() != 0);
        repeat (SETTLE_COUNT) @(posedge i_clk);
    endtask

    // APB read of path_length, compared with the programmed value.
    task automatic check_length_readback();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_PATH_LENGTH;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== 32'(cfg_path_length)) begin
            $error("prdata mismatch: expected %0d, actual %0d", cfg_path_length, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // APB write of path_length, only once the unit has gone idle.
    task automatic write_path_length(input logic [CFG_W-1:0] value);
        wait_idle();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PATH_LENGTH;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_path_length = value;
        check_length_readback();
    endtask

    // Each reply is matched against the oldest outstanding query.
    always @(posedge i_clk) begin
        t_depth_reply want;
        if (i_rst_n === 1'b1 && o_result_valid !== 1'b0) begin
            if (replies_due.size() == 0) begin
                $error("reply with no query outstanding: depth %0d, out_of_range %0b",
                       o_depth, o_out_of_range);
                error_count++;
            end else begin
                want = replies_due.pop_front();
                if (o_depth !== want.depth) begin
                    $error("depth mismatch: expected %0d, actual %0d", want.depth, o_depth);
                    error_count++;
                end
                if (o_out_of_range !== want.off_path) begin
                    $error("out_of_range mismatch: expected %0b, actual %0b",
                           want.off_path, o_out_of_range);
                    error_count++;
                end
            end
        end
    end

    // Hang detection: too long without a request or a reply moving.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_result_valid === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // After the clearing pass, the length is zero and every position is off path.
    task automatic test_reset_state();
        check_length_readback();
        send_request(OP_QUERY, 16'd0, 16'd0, 16'd0);
        send_request(OP_QUERY, 16'd4095, 16'hFFFF, 16'hFFFF);
        send_request(OP_ADD, 16'd0, 16'd0, 16'd100);
        send_request(OP_QUERY, 16'd0, 16'd0, 16'd0);
    endtask

    // Each op, span truncation at the path end and the empty-span cases.
    task automatic test_basic_ops();
        write_path_length(13'd64);
        send_request(OP_ADD, 16'd0, 16'd0, 16'd10);
        send_request(OP_ADD, 16'd60, 16'd0, 16'hFFFF);
        send_request(OP_ADD, 16'd64, 16'd0, 16'd5);
        send_request(OP_ADD, 16'hFFFF, 16'd0, 16'hFFFF);
        send_request(OP_ADD, 16'd5, 16'd10, 16'd10);
        send_request(OP_ADD, 16'd5, 16'hFFFF, 16'hFFFE);
        send_request(OP_ADD, 16'd0, 16'd0, 16'd0);
        send_request(OP_ADD, 16'd10, 16'hFFFE, 16'hFFFF);
        send_request(OP_QUERY, 16'd0, 16'd0, 16'd0);
        send_request(OP_QUERY, 16'd9, 16'd0, 16'd0);
        send_request(OP_QUERY, 16'd10, 16'd0, 16'd0);
        send_request(OP_QUERY, 16'd63, 16'd0, 16'd0);
        send_request(OP_QUERY, 16'd64, 16'd0, 16'd0);
        send_request(OP_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_UNUSED, 16'd9, 16'd0, 16'hFFFF);
        send_request(OP_QUERY, 16'd9, 16'd0, 16'd0);
        send_request(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_QUERY, 16'd0, 16'd0, 16'd0);
        send_request(OP_QUERY, 16'd63, 16'd0, 16'd0);
    endtask

    // A length above the store size acts as the store size.
    task automatic test_length_limits();
        write_path_length(13'h1FFF);
        send_request(OP_ADD, 16'd4090, 16'd0, 16'hFFFF);
        send_request(OP_ADD, 16'd0, 16'd0, 16'hFFFF);
        send_request(OP_QUERY, 16'd4095, 16'd0, 16'd0);
        send_request(OP_QUERY, 16'd4096, 16'd0, 16'd0);
        send_request(OP_QUERY, 16'd0, 16'd0, 16'd0);
        write_path_length(13'd4096);
        send_request(OP_QUERY, 16'd4095, 16'd0, 16'd0);
        write_path_length(13'd1);
        send_request(OP_ADD, 16'd0, 16'd0, 16'd3);
        send_request(OP_QUERY, 16'd0, 16'd0, 16'd0);
        send_request(OP_QUERY, 16'd1, 16'd0, 16'd0);
    endtask

    // Shrinking the length hides counts; growing it shows them again.
    task automatic test_length_shrink();
        write_path_length(13'd100);
        send_request(OP_ADD, 16'd50, 16'd0, 16'd50);
        write_path_length(13'd40);
        send_request(OP_QUERY, 16'd60, 16'd0, 16'd0);
        send_request(OP_ADD, 16'd30, 16'd0, 16'd40);
        write_path_length(13'd100);
        send_request(OP_QUERY, 16'd60, 16'd0, 16'd0);
        send_request(OP_QUERY, 16'd35, 16'd0, 16'd0);
        send_request(OP_QUERY, 16'd45, 16'd0, 16'd0);
    endtask

    // Stack many back-to-back single-position spans on one position.
    task automatic test_count_buildup();
        write_path_length(13'd16);
        steady_flow = 1'b1;
        repeat (30) send_request(OP_ADD, 16'd15, 16'd0, 16'hFFFF);
        send_request(OP_ADD, 16'd14, 16'd7, 16'd8);
        send_request(OP_QUERY, 16'd15, 16'd0, 16'd0);
        send_request(OP_QUERY, 16'd14, 16'd0, 16'd0);
        steady_flow = 1'b0;
    endtask

    // Random traffic over several path lengths: mostly well-formed placements
    // and queries near them, plus raw noise, unused codes and rare clears.
    task automatic test_random_traffic();
        logic [CFG_W-1:0]   lengths [8];
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] ppos, rpos, rlen;
        int                 plen, pick, span, last_add_pos;
        lengths[0] = 13'd4096;
        lengths[1] = 13'($urandom_range(17, 4095));
        lengths[2] = 13'd0;
        lengths[3] = 13'd300;
        lengths[4] = 13'($urandom_range(4097, 8190));
        lengths[5] = 13'd1;
        lengths[6] = 13'h1FFF;
        lengths[7] = 13'd16;
        last_add_pos = 0;
        foreach (lengths[phase]) begin
            write_path_length(lengths[phase]);
            plen = visible_length();
            for (int n = 0; n < 155; n++) begin
                if (n % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                rpos = FIELD_W'($urandom);
                rlen = FIELD_W'($urandom);
                if (pick < 8) begin
                    op   = OP_W'($urandom_range(0, 3));
                    ppos = FIELD_W'($urandom);
                end else if (pick < 12) begin
                    op   = OP_UNUSED;
                    ppos = FIELD_W'($urandom);
                end else if (pick < 14) begin
                    op   = OP_CLEAR;
                    ppos = FIELD_W'($urandom);
                end else if (pick < 62) begin
                    op   = OP_ADD;
                    last_add_pos = $urandom_range(0, plen + 4);
                    ppos = FIELD_W'(last_add_pos);
                    span = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4200)
                                                        : $urandom_range(1, 300);
                    rpos = $urandom_range(0, 1) ? FIELD_W'($urandom_range(0, 60))
                                                : FIELD_W'($urandom_range(0, 65535 - span));
                    rlen = rpos + FIELD_W'(span);
                end else begin
                    op = OP_QUERY;
                    case ($urandom_range(0, 9))
                        0:       ppos = FIELD_W'($urandom);
                        1, 2, 3: ppos = FIELD_W'($urandom_range(0, plen + 2));
                        default: ppos = FIELD_W'(last_add_pos + $urandom_range(0, 300));
                    endcase
                end
                send_request(op, ppos, rpos, rlen);
            end
        end
        steady_flow = 1'b0;
    endtask

    // Test sequence.
    initial begin
        // The unit's store comes out of reset cleared, so the copy starts cleared.
        foreach (coverage_counts[i]) coverage_counts[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_basic_ops();
        test_length_limits();
        test_length_shrink();
        test_count_buildup();
        test_random_traffic();
        wait_idle();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
